### rtl/rht_pkg.sv
// shared types and constants for the rendezvous hash ranking block
`default_nettype none
package rht_pkg;

	localparam int MaxMembers = 64;
	localparam int IdxW = $clog2(MaxMembers);
	localparam int CntW = $clog2(MaxMembers + 1);
	localparam int QDepth = 2;

	localparam logic CMD_KEY = 1'b0;
	localparam logic CMD_MEMBER = 1'b1;

	typedef struct packed {
		logic [0:0] command;
		logic [1:0] key_word_index;
		logic [63:0] key_word;
		logic [7:0] member_id;
		logic [0:0] last_member;
		logic [6:0] wanted_count;
	} req_t;

	typedef struct packed {
		logic [7:0] ranked_id;
		logic [0:0] status;
		logic [0:0] last_result;
	} rsp_t;

	// work handed from the front to the back
	typedef struct packed {
		logic [63:0] weight;
		logic [7:0] id;
		logic last;
		logic [6:0] wanted;
	} job_t;

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
		32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
		32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
		32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
		32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
		32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
		32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
		32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
		32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
		32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
		32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

	localparam logic [255:0] InitH = {32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
		32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage
`default_nettype wire

### rtl/rht_if.sv
// valid/ready channel carrying one payload
`default_nettype none
interface rht_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/rht_front.sv
// front: key storage and iterative sha-256 weight of each member
`default_nettype none
module rht_front (
	input wire logic clk,
	input wire logic arst_n,
	rht_if.sink req,
	output rht_pkg::job_t job,
	output logic job_valid,
	input wire logic job_ready
);
	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_RUN = 3'b010,
		F_DONE = 3'b100
	} fstate_t;

	fstate_t state_q;
	logic [63:0] key_q [4];
	logic [31:0] w_q [16];
	logic [31:0] s_q [8];
	logic [6:0] rnd_q;
	logic [7:0] id_q;
	logic last_q;
	logic [6:0] wanted_q;

	logic [31:0] wnew, e1, ch, t1, e0, mj, s0x, s1x, h0, h1;

	always_comb begin
		s0x = rht_pkg::rotr(w_q[1], 7) ^ rht_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1x = rht_pkg::rotr(w_q[14], 17) ^ rht_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wnew = w_q[0] + s0x + w_q[9] + s1x;
		e1 = rht_pkg::rotr(s_q[4], 6) ^ rht_pkg::rotr(s_q[4], 11) ^ rht_pkg::rotr(s_q[4], 25);
		ch = (s_q[4] & s_q[5]) ^ (~s_q[4] & s_q[6]);
		t1 = s_q[7] + e1 + ch + rht_pkg::RoundK[rnd_q[5:0]] + w_q[0];
		e0 = rht_pkg::rotr(s_q[0], 2) ^ rht_pkg::rotr(s_q[0], 13) ^ rht_pkg::rotr(s_q[0], 22);
		mj = (s_q[0] & s_q[1]) ^ (s_q[0] & s_q[2]) ^ (s_q[1] & s_q[2]);
		h0 = rht_pkg::InitH[255:224] + s_q[0];
		h1 = rht_pkg::InitH[223:192] + s_q[1];
	end

	assign req.ready = (state_q == F_IDLE);
	assign job_valid = (state_q == F_DONE);
	assign job.weight = {h0, h1};
	assign job.id = id_q;
	assign job.last = last_q;
	assign job.wanted = wanted_q;

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			if (req.data.command == rht_pkg::CMD_KEY) begin
				key_q[req.data.key_word_index] <= req.data.key_word;
			end else begin
				for (int i = 0; i < 4; i++) begin
					w_q[2*i] <= key_q[i][63:32];
					w_q[2*i+1] <= key_q[i][31:0];
				end
				w_q[8] <= {req.data.member_id, 24'h800000};
				for (int i = 9; i < 15; i++) w_q[i] <= '0;
				w_q[15] <= 32'd264;
				for (int i = 0; i < 8; i++) s_q[i] <= rht_pkg::InitH[255-32*i -: 32];
				id_q <= req.data.member_id;
				last_q <= req.data.last_member;
				wanted_q <= req.data.wanted_count;
			end
		end else if (state_q == F_RUN) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
			s_q[7] <= s_q[6];
			s_q[6] <= s_q[5];
			s_q[5] <= s_q[4];
			s_q[4] <= s_q[3] + t1;
			s_q[3] <= s_q[2];
			s_q[2] <= s_q[1];
			s_q[1] <= s_q[0];
			s_q[0] <= t1 + e0 + mj;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			rnd_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (req.valid && req.data.command == rht_pkg::CMD_MEMBER) begin
						state_q <= F_RUN;
						rnd_q <= '0;
					end
				end
				F_RUN: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd63) state_q <= F_DONE;
				end
				F_DONE: if (job_ready) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == F_RUN |-> rnd_q < 7'd64) else $error("round counter out of range");
	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(job_valid) |-> $past(state_q) == F_RUN) else $error("job without compression");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != F_IDLE |-> !req.ready) else $error("request taken while busy");
`endif
endmodule
`default_nettype wire

### rtl/rht_queue.sv
// small fifo between front and back
`default_nettype none
module rht_queue (
	input wire logic clk,
	input wire logic arst_n,
	input rht_pkg::job_t in_job,
	input wire logic in_valid,
	output logic in_ready,
	output rht_pkg::job_t out_job,
	output logic out_valid,
	input wire logic out_ready
);
	rht_pkg::job_t mem_q [rht_pkg::QDepth];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_job = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef SYNTH
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue overfilled");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) |-> (wp_q != rp_q)) else $error("queue pointers out of step");
	a_empty_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> (wp_q == rp_q)) else $error("queue pointers out of step");
`endif
endmodule
`default_nettype wire

### rtl/rht_back.sv
// back: sorted insert into the ranking table and result emission
`default_nettype none
module rht_back (
	input wire logic clk,
	input wire logic arst_n,
	input rht_pkg::job_t job,
	input wire logic job_valid,
	output logic job_ready,
	rht_if.source rsp
);
	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_SHIFT = 5'b00010,
		B_CHECK = 5'b00100,
		B_READ = 5'b01000,
		B_EMIT = 5'b10000
	} bstate_t;

	bstate_t state_q;
	logic [63:0] score_q [rht_pkg::MaxMembers];
	logic [7:0] ids_q [rht_pkg::MaxMembers];
	logic [rht_pkg::CntW-1:0] count_q;
	logic ovf_q;
	logic [rht_pkg::CntW-1:0] pos_q;
	logic [63:0] wt_q;
	logic [7:0] id_q;
	logic last_q;
	logic [6:0] wanted_q;
	logic [rht_pkg::CntW-1:0] take_q;
	logic [rht_pkg::CntW-1:0] k_q;
	logic [63:0] rd_score_q;
	logic [7:0] rd_id_q;
	logic rd_ok_q;
	logic [rht_pkg::IdxW-1:0] rd_addr;
	logic beats, full, move, fail, final_k, fire_ok, fire_err;
	logic [rht_pkg::CntW-1:0] cnt_next, take_c;

	assign job_ready = (state_q == B_IDLE) && !rsp.valid;
	assign beats = (wt_q > rd_score_q) || (wt_q == rd_score_q && id_q < rd_id_q);
	assign full = (count_q == rht_pkg::CntW'(rht_pkg::MaxMembers));
	assign move = !full && pos_q != '0 && rd_ok_q && beats;
	assign fail = (wanted_q == '0) || ovf_q || full;
	assign cnt_next = count_q + 1'b1;
	assign take_c = (rht_pkg::CntW'(wanted_q) < cnt_next) ? rht_pkg::CntW'(wanted_q) : cnt_next;
	assign final_k = (k_q + 1'b1 == take_q);
	assign fire_ok = (state_q == B_EMIT) && (!rsp.valid || rsp.ready);
	assign fire_err = (state_q == B_CHECK) && !move && last_q && fail;

	always_comb begin
		if (state_q == B_READ || state_q == B_EMIT) rd_addr = k_q[rht_pkg::IdxW-1:0];
		else if (state_q == B_IDLE) rd_addr = rht_pkg::IdxW'(count_q - 1'b1);
		else rd_addr = rht_pkg::IdxW'(pos_q - 1'b1);
	end

	// table memory, one read and one write port
	always_ff @(posedge clk) begin
		rd_score_q <= score_q[rd_addr];
		rd_id_q <= ids_q[rd_addr];
		if (state_q == B_CHECK && !full) begin
			if (move) begin
				score_q[pos_q[rht_pkg::IdxW-1:0]] <= rd_score_q;
				ids_q[pos_q[rht_pkg::IdxW-1:0]] <= rd_id_q;
			end else begin
				score_q[pos_q[rht_pkg::IdxW-1:0]] <= wt_q;
				ids_q[pos_q[rht_pkg::IdxW-1:0]] <= id_q;
			end
		end
		if (job_valid && job_ready) begin
			wt_q <= job.weight;
			id_q <= job.id;
			last_q <= job.last;
			wanted_q <= job.wanted;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			count_q <= '0;
			ovf_q <= 1'b0;
			pos_q <= '0;
			rd_ok_q <= 1'b0;
			take_q <= '0;
			k_q <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (job_valid && job_ready) begin
						pos_q <= count_q;
						rd_ok_q <= (count_q != '0);
						state_q <= B_CHECK;
					end
				end
				B_SHIFT: state_q <= B_CHECK;
				B_CHECK: begin
					if (move) begin
						pos_q <= pos_q - 1'b1;
						rd_ok_q <= (pos_q != rht_pkg::CntW'(1));
						state_q <= B_SHIFT;
					end else if (!last_q) begin
						if (full) ovf_q <= 1'b1;
						else count_q <= cnt_next;
						state_q <= B_IDLE;
					end else if (fail) begin
						count_q <= '0;
						ovf_q <= 1'b0;
						state_q <= B_IDLE;
					end else begin
						take_q <= take_c;
						k_q <= '0;
						count_q <= '0;
						state_q <= B_READ;
					end
				end
				B_READ: state_q <= B_EMIT;
				B_EMIT: begin
					if (fire_ok) begin
						k_q <= k_q + 1'b1;
						state_q <= final_k ? B_IDLE : B_READ;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
			rsp.data <= '0;
		end else if (fire_err) begin
			rsp.valid <= 1'b1;
			rsp.data <= '{ranked_id: 8'd0, status: 1'b1, last_result: 1'b1};
		end else if (fire_ok) begin
			rsp.valid <= 1'b1;
			rsp.data <= '{ranked_id: rd_id_q, status: 1'b0, last_result: final_k};
		end else if (rsp.ready) begin
			rsp.valid <= 1'b0;
		end
	end

`ifndef SYNTH
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rht_pkg::CntW'(rht_pkg::MaxMembers)) else $error("member count too big");
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.status |-> rsp.data.last_result) else $error("error not last");
	a_take_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_READ || state_q == B_EMIT) |-> k_q < take_q)
		else $error("emitted past take");
`endif
endmodule
`default_nettype wire

### rtl/rendezvous_hash_top_r_unit.sv
// top level of the rendezvous hash ranking block
// channels: req (valid/ready, rht_pkg::req_t) carries key-word and member requests,
// rsp (valid/ready, rht_pkg::rsp_t) carries ranked ids, error flag and last mark.
// a key-word request is stored and gives no result.
// a member request runs one sha-256 compression, 64 rounds on one shared round
// unit, and the front takes the next request only after its weight is handed on.
// the back inserts the weight into the sorted table with one read and one write
// port, moving each entry in a check and a shift state, overlapped with the
// next compression via a two-entry queue.
// on the last member the back streams min(wanted, count) ids, each via a read and an
// emit state, or one error result when wanted is zero or the table overflowed.
// reset clears counters and control; key and table contents are undefined.
// when rsp is stalled the result is held and the back stops; the queue fills
// and then the front stops taking requests.
`default_nettype none
module rendezvous_hash_top_r_unit (
	input wire logic clk,
	input wire logic arst_n,
	rht_if.sink req,
	rht_if.source rsp
);
	rht_pkg::job_t f_job, b_job;
	logic f_valid, f_ready, b_valid, b_ready;

	rht_front u_front (.clk, .arst_n, .req, .job(f_job), .job_valid(f_valid),
		.job_ready(f_ready));
	rht_queue u_queue (.clk, .arst_n, .in_job(f_job), .in_valid(f_valid), .in_ready(f_ready),
		.out_job(b_job), .out_valid(b_valid), .out_ready(b_ready));
	rht_back u_back (.clk, .arst_n, .job(b_job), .job_valid(b_valid), .job_ready(b_ready),
		.rsp);
endmodule
`default_nettype wire
